// ----- src/wsd_pkg.sv -----
`default_nettype none

package wsd_pkg;

   // Width of both configuration registers and of the write data.
   localparam int unsigned REG_BITS = 23;
   localparam int unsigned CSR_INDEX_BITS = 1;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] REG_MIN_WEIGHT       = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STABLE_THRESHOLD = 1'd1;

   // Register reset values, in grams.
   localparam logic [REG_BITS-1:0] MIN_WEIGHT_RESET       = 23'd1;
   localparam logic [REG_BITS-1:0] STABLE_THRESHOLD_RESET = 23'd50;

   // Status reported with every result word.
   typedef enum logic [1:0] {
      ST_WAITING     = 2'd0,
      ST_RISING      = 2'd1,
      ST_STABILIZING = 2'd2,
      ST_STABLE      = 2'd3
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      CS_IDLE = 2'd0,
      CS_SCAN = 2'd1,
      CS_DONE = 2'd2
   } ctrl_state_type;

endpackage

`default_nettype wire

// ----- src/wsd_chan_if.sv -----
`default_nettype none

// Sample channel: one signed weight sample per word.
interface wsd_req_if #(
   parameter int unsigned SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] weight_sample;

   modport source (output valid, output weight_sample, input ready);
   modport sink   (input valid, input weight_sample, output ready);
endinterface

// Result channel: status, one-shot event flag and the weight sent with it.
interface wsd_rsp_if #(
   parameter int unsigned SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic                          stable_event;
   logic signed [SAMPLE_BITS-1:0] stable_weight;

   modport source (output valid, output status, output stable_event, output stable_weight,
                   input ready);
   modport sink   (input valid, input status, input stable_event, input stable_weight,
                   output ready);
endinterface

`default_nettype wire

// ----- src/weight_stability_detector.sv -----
// Weight stability detector for a load-cell scale.
// Input channel req_chan carries one signed weight sample (grams) per word;
// result channel rsp_chan returns exactly one word per sample: status,
// stable_event and stable_weight. Both use valid/ready; a word moves when
// both are high. min_weight and stable_threshold are written through the
// csr_ port; the user must write them only while the block is idle, as
// the block itself does not enforce this. A sample that is empty, arrives
// after the event, or leaves the window not yet full passes through the
// done state straight into the result register. A sample that completes a
// full window first passes through the scan state, in which the min and
// max travel through the chain of WINDOW_LEN slot cells, one cell per
// cycle, and then the done state, where the spread is compared. A new
// sample is taken in the cycle after the previous result is loaded.
// Reset (synchronous, active high) empties the window, clears the one-shot
// flag, sets status to waiting and restores the register defaults.
// When the receiver stalls, the result register holds its word and the next
// sample is still accepted; that sample's result waits in the controller
// until the register frees, and no further sample is taken meanwhile.
`default_nettype none

module weight_stability_detector
   import wsd_pkg::*;
#(
   parameter int unsigned WINDOW_LEN  = 5,
   parameter int unsigned SAMPLE_BITS = 24
) (
   input  wire                        clock,
   input  wire                        reset,
   wsd_req_if.sink                    req_chan,
   wsd_rsp_if.source                  rsp_chan,
   input  wire                        csr_wr_en,
   input  wire [CSR_INDEX_BITS-1:0]   csr_index,
   input  wire [REG_BITS-1:0]         csr_wr_data
);

   localparam int unsigned CNT_BITS = $clog2(WINDOW_LEN + 1);
   localparam int unsigned CMP_BITS =
      ((SAMPLE_BITS > REG_BITS) ? SAMPLE_BITS : REG_BITS) + 2;
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(WINDOW_LEN);
   localparam logic [CNT_BITS-1:0] LAST_COUNT = CNT_BITS'(WINDOW_LEN - 1);

   ctrl_state_type                state_ff, state_in;
   logic [CNT_BITS-1:0]           fill_ff, fill_in;
   logic [CNT_BITS-1:0]           scan_cnt_ff, scan_cnt_in;
   logic                          event_sent_ff, event_sent_in;
   status_type                    last_status_ff, last_status_in;
   logic                          pend_scan_ff, pend_scan_in;
   logic signed [SAMPLE_BITS-1:0] pend_sample_ff, pend_sample_in;
   logic [REG_BITS-1:0]           min_weight_ff, min_weight_in;
   logic [REG_BITS-1:0]           stable_threshold_ff, stable_threshold_in;
   logic                          out_valid_ff, out_valid_in;
   status_type                    out_status_ff, out_status_in;
   logic                          out_event_ff, out_event_in;
   logic signed [SAMPLE_BITS-1:0] out_weight_ff, out_weight_in;

   logic                          req_fire;
   logic                          out_free;
   logic                          shift_en;
   logic                          is_empty;
   logic                          full_after;
   logic                          is_stable;
   logic signed [CMP_BITS-1:0]    sample_ext;
   logic signed [CMP_BITS-1:0]    min_ext;
   logic signed [CMP_BITS-1:0]    spread;
   logic signed [CMP_BITS-1:0]    thr_ext;

   logic signed [SAMPLE_BITS-1:0] win_val [WINDOW_LEN];
   logic signed [SAMPLE_BITS-1:0] lo_link [WINDOW_LEN];
   logic signed [SAMPLE_BITS-1:0] hi_link [WINDOW_LEN];

   // Window chain: a new sample enters at cell 0 and the oldest drops off the end.
   for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
      if (i == 0) begin : g_head
         wsd_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
            .clock      (clock),
            .shift_en   (shift_en),
            .sample_in  (req_chan.weight_sample),
            .sample_out (win_val[i]),
            .lo_in      (win_val[i]),
            .hi_in      (win_val[i]),
            .lo_out     (lo_link[i]),
            .hi_out     (hi_link[i])
         );
      end else begin : g_body
         wsd_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
            .clock      (clock),
            .shift_en   (shift_en),
            .sample_in  (win_val[i-1]),
            .sample_out (win_val[i]),
            .lo_in      (lo_link[i-1]),
            .hi_in      (hi_link[i-1]),
            .lo_out     (lo_link[i]),
            .hi_out     (hi_link[i])
         );
      end
   end

   // Compares: empty scale on the incoming sample, spread at the chain's end.
   always_comb begin
      req_fire   = req_chan.valid && req_chan.ready;
      out_free   = !out_valid_ff || rsp_chan.ready;
      sample_ext = CMP_BITS'(req_chan.weight_sample);
      min_ext    = $signed(CMP_BITS'(min_weight_ff));
      is_empty   = sample_ext < min_ext;
      full_after = fill_ff >= LAST_COUNT;
      spread     = CMP_BITS'(hi_link[WINDOW_LEN-1]) - CMP_BITS'(lo_link[WINDOW_LEN-1]);
      thr_ext    = $signed(CMP_BITS'(stable_threshold_ff));
      is_stable  = spread < thr_ext;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_IDLE: begin
            if (req_fire) begin
               if (!is_empty && !event_sent_ff && full_after) begin
                  state_in = CS_SCAN;
               end else begin
                  state_in = CS_DONE;
               end
            end
         end
         CS_SCAN: begin
            if (scan_cnt_ff == LAST_COUNT) begin
               state_in = CS_DONE;
            end
         end
         CS_DONE: begin
            if (out_free) begin
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   // Datapath and outputs for each state.
   always_comb begin
      req_chan.ready = 1'b0;
      shift_en       = 1'b0;
      fill_in        = fill_ff;
      scan_cnt_in    = scan_cnt_ff;
      event_sent_in  = event_sent_ff;
      last_status_in = last_status_ff;
      pend_scan_in   = pend_scan_ff;
      pend_sample_in = pend_sample_ff;
      out_valid_in   = out_valid_ff && !rsp_chan.ready;
      out_status_in  = out_status_ff;
      out_event_in   = out_event_ff;
      out_weight_in  = out_weight_ff;
      case (state_ff)
         CS_IDLE: begin
            req_chan.ready = 1'b1;
            scan_cnt_in    = '0;
            pend_sample_in = req_chan.weight_sample;
            pend_scan_in   = 1'b0;
            if (req_fire) begin
               if (is_empty) begin
                  fill_in        = '0;
                  event_sent_in  = 1'b0;
                  last_status_in = ST_WAITING;
               end else if (!event_sent_ff) begin
                  shift_en = 1'b1;
                  if (fill_ff < FULL_COUNT) begin
                     fill_in = fill_ff + 1'b1;
                  end
                  if (full_after) begin
                     pend_scan_in = 1'b1;
                  end else begin
                     last_status_in = ST_RISING;
                  end
               end
            end
         end
         CS_SCAN: begin
            scan_cnt_in = scan_cnt_ff + 1'b1;
         end
         CS_DONE: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_event_in  = 1'b0;
               out_weight_in = '0;
               out_status_in = last_status_ff;
               if (pend_scan_ff) begin
                  if (is_stable) begin
                     event_sent_in  = 1'b1;
                     last_status_in = ST_STABLE;
                     out_status_in  = ST_STABLE;
                     out_event_in   = 1'b1;
                     out_weight_in  = pend_sample_ff;
                  end else begin
                     last_status_in = ST_STABILIZING;
                     out_status_in  = ST_STABILIZING;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Configuration writes.
   always_comb begin
      min_weight_in       = min_weight_ff;
      stable_threshold_in = stable_threshold_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_MIN_WEIGHT:       min_weight_in       = csr_wr_data;
            REG_STABLE_THRESHOLD: stable_threshold_in = csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= CS_IDLE;
         fill_ff             <= '0;
         scan_cnt_ff         <= '0;
         event_sent_ff       <= 1'b0;
         last_status_ff      <= ST_WAITING;
         pend_scan_ff        <= 1'b0;
         min_weight_ff       <= MIN_WEIGHT_RESET;
         stable_threshold_ff <= STABLE_THRESHOLD_RESET;
         out_valid_ff        <= 1'b0;
      end else begin
         state_ff            <= state_in;
         fill_ff             <= fill_in;
         scan_cnt_ff         <= scan_cnt_in;
         event_sent_ff       <= event_sent_in;
         last_status_ff      <= last_status_in;
         pend_scan_ff        <= pend_scan_in;
         min_weight_ff       <= min_weight_in;
         stable_threshold_ff <= stable_threshold_in;
         out_valid_ff        <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_sample_ff <= pend_sample_in;
      out_status_ff  <= out_status_in;
      out_event_ff   <= out_event_in;
      out_weight_ff  <= out_weight_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.status        = out_status_ff;
   assign rsp_chan.stable_event  = out_event_ff;
   assign rsp_chan.stable_weight = out_weight_ff;

   // The event word always reports the stable status.
   a_event_is_stable: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_event_ff) |-> (out_status_ff == ST_STABLE))
      else $error("stable event without stable status");

   // The weight field is zero on every word without the event.
   a_weight_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_event_ff) |-> (out_weight_ff == '0))
      else $error("stable weight set without event");

   // A scan only runs over a full window.
   a_scan_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_SCAN) |-> (fill_ff == FULL_COUNT))
      else $error("scan started on a partial window");

   // The one-shot flag is set only when a result is loaded after a scan.
   a_event_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(event_sent_ff) |-> ($past(state_ff) == CS_DONE && $past(pend_scan_ff)))
      else $error("one-shot flag set outside a scan result");

endmodule

`default_nettype wire

// ----- src/wsd_cell.sv -----
`default_nettype none

// One window slot. The sample moves one cell down the chain on every shift,
// so the cell at the far end always holds the oldest sample. A running
// minimum and maximum pass through the chain one cell per cycle.
module wsd_cell
   import wsd_pkg::*;
#(
   parameter int unsigned SAMPLE_BITS = 24
) (
   input  wire                          clock,
   input  wire                          shift_en,
   input  wire signed [SAMPLE_BITS-1:0] sample_in,
   output logic signed [SAMPLE_BITS-1:0] sample_out,
   input  wire signed [SAMPLE_BITS-1:0] lo_in,
   input  wire signed [SAMPLE_BITS-1:0] hi_in,
   output logic signed [SAMPLE_BITS-1:0] lo_out,
   output logic signed [SAMPLE_BITS-1:0] hi_out
);

   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SAMPLE_BITS-1:0] lo_ff;
   logic signed [SAMPLE_BITS-1:0] hi_ff;
   logic signed [SAMPLE_BITS-1:0] lo_fold_in;
   logic signed [SAMPLE_BITS-1:0] hi_fold_in;

   // Fold this slot into the running extremes.
   always_comb begin
      lo_fold_in = (sample_ff < lo_in) ? sample_ff : lo_in;
      hi_fold_in = (sample_ff > hi_in) ? sample_ff : hi_in;
   end

   // Payload only: the controller never scans a slot before it is filled.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         sample_ff <= sample_in;
      end
      lo_ff <= lo_fold_in;
      hi_ff <= hi_fold_in;
   end

   assign sample_out = sample_ff;
   assign lo_out     = lo_ff;
   assign hi_out     = hi_ff;

endmodule

`default_nettype wire

// ----- dv/weight_stability_detector_test.sv -----
`default_nettype none

module weight_stability_detector_test;
   import wsd_pkg::*;

   localparam int unsigned WIN_LEN     = 5;
   localparam int unsigned SAMPLE_BITS = 24;
   localparam int          MAX_GRAMS   = 8388607;
   localparam int          MIN_GRAMS   = -8388608;
   localparam int          REG_MAX     = 8388607;

   typedef enum logic [1:0] {
      JOB_SAMPLE,
      JOB_CSR,
      JOB_SETTLE
   } job_kind_type;

   typedef struct {
      job_kind_type                  kind;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [CSR_INDEX_BITS-1:0]     index;
      logic [REG_BITS-1:0]           data;
      bit                            tail;
   } job_type;

   typedef struct {
      status_type                    status;
      logic                          fired;
      logic signed [SAMPLE_BITS-1:0] weight;
   } scale_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      csr_wr_en   = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [REG_BITS-1:0]       csr_wr_data = '0;

   wsd_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_if ();
   wsd_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_if ();

   weight_stability_detector #(
      .WINDOW_LEN (WIN_LEN),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_if),
      .rsp_chan   (rsp_if),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // Scale model state and its copy of the registers.
   logic signed [SAMPLE_BITS-1:0] scale_slots [WIN_LEN];
   int unsigned                   slots_filled = 0;
   int unsigned                   oldest_slot  = 0;
   bit                            event_fired  = 1'b0;
   status_type                    held_status  = ST_WAITING;
   logic [REG_BITS-1:0]           empty_below  = MIN_WEIGHT_RESET;
   logic [REG_BITS-1:0]           spread_limit = STABLE_THRESHOLD_RESET;

   job_type        pending_jobs [$];
   scale_word_type expected_words [$];

   int unsigned issued_count    = 0;
   int unsigned retired_count   = 0;
   int unsigned mismatch_count  = 0;
   int unsigned unexpected_count = 0;
   int unsigned reported        = 0;
   int unsigned events_seen     = 0;
   int unsigned csr_writes      = 0;
   int unsigned status_seen [4] = '{0, 0, 0, 0};
   bit          quiet_tail      = 1'b0;
   int unsigned gap_left        = 0;
   int unsigned stall_left      = 0;
   int unsigned samples_planned = 0;

   // Predict the result word for one accepted sample and advance the scale state.
   function automatic scale_word_type weigh(logic signed [SAMPLE_BITS-1:0] sample);
      scale_word_type word;
      int          grams;
      int          lo;
      int          hi;
      grams       = sample;
      word.fired  = 1'b0;
      word.weight = '0;
      if (grams < int'(empty_below)) begin
         slots_filled = 0;
         oldest_slot  = 0;
         event_fired  = 1'b0;
         held_status  = ST_WAITING;
      end else if (!event_fired) begin
         scale_slots[oldest_slot] = sample;
         oldest_slot = (oldest_slot == WIN_LEN - 1) ? 0 : oldest_slot + 1;
         if (slots_filled < WIN_LEN) slots_filled++;
         if (slots_filled >= WIN_LEN) begin
            lo = scale_slots[0];
            hi = scale_slots[0];
            for (int i = 1; i < WIN_LEN; i++) begin
               if (int'(scale_slots[i]) < lo) lo = scale_slots[i];
               if (int'(scale_slots[i]) > hi) hi = scale_slots[i];
            end
            if (hi - lo < int'(spread_limit)) begin
               event_fired = 1'b1;
               word.fired  = 1'b1;
               word.weight = sample;
               held_status = ST_STABLE;
            end else begin
               held_status = ST_STABILIZING;
            end
         end else begin
            held_status = ST_RISING;
         end
      end
      word.status = held_status;
      return word;
   endfunction

   function automatic void queue_sample(int grams, bit tail);
      job_type job;
      job.kind   = JOB_SAMPLE;
      job.sample = grams[SAMPLE_BITS-1:0];
      job.index  = '0;
      job.data   = '0;
      job.tail   = tail;
      pending_jobs.push_back(job);
      samples_planned++;
   endfunction

   function automatic void queue_csr(logic [CSR_INDEX_BITS-1:0] index, int unsigned value);
      job_type job;
      job.kind   = JOB_CSR;
      job.sample = '0;
      job.index  = index;
      job.data   = value[REG_BITS-1:0];
      job.tail   = 1'b0;
      pending_jobs.push_back(job);
   endfunction

   function automatic void queue_settle();
      job_type job;
      job.kind   = JOB_SETTLE;
      job.sample = '0;
      job.index  = '0;
      job.data   = '0;
      job.tail   = 1'b0;
      pending_jobs.push_back(job);
   endfunction

   // A reading that the current minimum treats as an empty scale.
   function automatic int empty_reading(int unsigned min_g);
      if (min_g > 0 && $urandom_range(0, 1) == 1) return $urandom_range(0, min_g - 1);
      return -int'($urandom_range(1, 8388608));
   endfunction

   // One load placed on the scale: empty readings, a ramp, a noisy settle, a hold.
   // A broken load stops after a short settle and empties again.
   function automatic void queue_weighing(int unsigned min_g, int unsigned thr_g, bit tail,
                                          bit broken);
      int base;
      int unsigned amp;
      int grams;
      int unsigned settle_len;
      for (int i = $urandom_range(1, 3); i > 0; i--) queue_sample(empty_reading(min_g), tail);
      base = int'(min_g) + int'($urandom_range(0, MAX_GRAMS - min_g));
      if (thr_g == 0) amp = $urandom_range(0, 2);
      else if ($urandom_range(0, 2) != 0) amp = $urandom_range(0, thr_g - 1);
      else amp = thr_g + $urandom_range(0, 100);
      for (int i = $urandom_range(0, 3); i > 0; i--) begin
         grams = int'(min_g) + int'($urandom_range(0, base - int'(min_g)));
         queue_sample(grams, tail);
      end
      settle_len = broken ? $urandom_range(1, WIN_LEN - 1) : WIN_LEN + $urandom_range(0, 4);
      for (int i = settle_len + (broken ? 0 : $urandom_range(0, 3)); i > 0; i--) begin
         grams = base + int'($urandom_range(0, amp));
         if (grams > MAX_GRAMS) grams = MAX_GRAMS;
         queue_sample(grams, tail);
      end
      queue_sample(empty_reading(min_g), tail);
   endfunction

   // Driver: one sample word or one register write at a time, with random gaps.
   always @(posedge clock) begin
      logic                          nxt_valid;
      logic signed [SAMPLE_BITS-1:0] nxt_sample;
      logic                          nxt_wr;
      logic [CSR_INDEX_BITS-1:0]     nxt_index;
      logic [REG_BITS-1:0]           nxt_data;
      bit                            idle;
      job_type                       job;
      if (reset) begin
         req_if.valid <= 1'b0;
         csr_wr_en    <= 1'b0;
      end else begin
         nxt_valid  = req_if.valid;
         nxt_sample = req_if.weight_sample;
         nxt_wr     = 1'b0;
         nxt_index  = csr_index;
         nxt_data   = csr_wr_data;
         idle       = !req_if.valid && issued_count == retired_count;
         if (req_if.valid && req_if.ready) begin
            expected_words.push_back(weigh(req_if.weight_sample));
            issued_count <= issued_count + 1;
            nxt_valid = 1'b0;
            if (!quiet_tail && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 10);
         end
         if (!nxt_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_jobs.size() != 0) begin
               job = pending_jobs[0];
               case (job.kind)
                  JOB_SAMPLE: begin
                     nxt_valid  = 1'b1;
                     nxt_sample = job.sample;
                     quiet_tail <= job.tail;
                     void'(pending_jobs.pop_front());
                  end
                  JOB_CSR: begin
                     // Registers change only with no word in flight.
                     if (idle) begin
                        nxt_wr    = 1'b1;
                        nxt_index = job.index;
                        nxt_data  = job.data;
                        case (job.index)
                           REG_MIN_WEIGHT:       empty_below  = job.data;
                           REG_STABLE_THRESHOLD: spread_limit = job.data;
                           default: ;
                        endcase
                        csr_writes++;
                        void'(pending_jobs.pop_front());
                     end
                  end
                  default: begin
                     if (idle) void'(pending_jobs.pop_front());
                  end
               endcase
            end
         end
         req_if.valid         <= nxt_valid;
         req_if.weight_sample <= nxt_sample;
         csr_wr_en            <= nxt_wr;
         csr_index            <= nxt_index;
         csr_wr_data          <= nxt_data;
      end
   end

   // Monitor: check each result word against the oldest prediction; stall at random.
   always @(posedge clock) begin
      scale_word_type want;
      bit          bad;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            retired_count <= retired_count + 1;
            if (!$isunknown(rsp_if.status)) status_seen[rsp_if.status]++;
            if (rsp_if.stable_event === 1'b1) events_seen++;
            if (expected_words.size() == 0) begin
               unexpected_count++;
               if (reported < 10)
                  $display("ERROR: unexpected word: status %0d event %0d weight %0d",
                           rsp_if.status, rsp_if.stable_event, rsp_if.stable_weight);
               reported++;
            end else begin
               want = expected_words.pop_front();
               bad  = rsp_if.status !== want.status || rsp_if.stable_event !== want.fired ||
                      rsp_if.stable_weight !== want.weight;
               if (bad) begin
                  mismatch_count++;
                  if (reported < 10)
                     $display("ERROR: word %0d expected %0d %0d %0d, got %0d %0d %0d",
                              retired_count, want.status, want.fired, want.weight,
                              rsp_if.status, rsp_if.stable_event, rsp_if.stable_weight);
                  reported++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 9);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Stimulus plan, reset and end of run.
   initial begin
      int unsigned min_g;
      int unsigned thr_g;
      int unsigned phase_goal;
      req_if.valid         = 1'b0;
      req_if.weight_sample = '0;
      rsp_if.ready         = 1'b0;
      for (int i = 0; i < WIN_LEN; i++) scale_slots[i] = '0;

      // Default registers: empty readings, a full-scale load, then a settled load.
      queue_sample(MIN_GRAMS, 1'b0);
      queue_sample(0, 1'b0);
      queue_sample(MAX_GRAMS, 1'b0);
      for (int i = 0; i < 5; i++) queue_sample(1000, 1'b0);
      queue_sample(1200, 1'b0);   // after the event nothing changes
      queue_sample(-1, 1'b0);
      // A zero threshold never settles; the largest minimum empties below full scale.
      queue_csr(REG_STABLE_THRESHOLD, 0);
      queue_csr(REG_MIN_WEIGHT, REG_MAX);
      for (int i = 0; i < 5; i++) queue_sample(MAX_GRAMS, 1'b0);
      queue_sample(MAX_GRAMS - 1, 1'b0);
      // Zero minimum and largest threshold: a negative reading is still empty.
      queue_csr(REG_MIN_WEIGHT, 0);
      queue_csr(REG_STABLE_THRESHOLD, REG_MAX);
      queue_sample(-1, 1'b0);
      queue_sample(0, 1'b0);
      queue_sample(MAX_GRAMS, 1'b0);
      for (int i = 0; i < 3; i++) queue_sample(0, 1'b0);
      queue_sample(MIN_GRAMS, 1'b0);
      for (int i = 0; i < 5; i++) queue_sample(0, 1'b0);

      // Random phases, each with its own register setting.
      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(0, 4))
            0: min_g = 0;
            1: min_g = 1;
            2: min_g = REG_MAX;
            3: min_g = $urandom_range(0, 5000);
            default: min_g = $urandom_range(0, REG_MAX);
         endcase
         case ($urandom_range(0, 4))
            0: thr_g = 0;
            1: thr_g = REG_MAX;
            2: thr_g = $urandom_range(1, 200);
            3: thr_g = $urandom_range(0, REG_MAX);
            default: thr_g = 50;
         endcase
         if (phase == 0) begin
            min_g = $urandom_range(0, REG_MAX);
            thr_g = $urandom_range(0, REG_MAX);
         end
         queue_csr(REG_MIN_WEIGHT, min_g);
         queue_csr(REG_STABLE_THRESHOLD, thr_g);
         phase_goal = samples_planned + 115;
         while (samples_planned < phase_goal) begin
            case ($urandom_range(0, 9))
               7: for (int i = $urandom_range(1, 4); i > 0; i--)
                     queue_sample(int'($urandom_range(0, 16777215)) - 8388608, 1'b0);
               8: queue_weighing(min_g, thr_g, 1'b0, 1'b1);
               9: queue_settle();
               default: queue_weighing(min_g, thr_g, 1'b0, 1'b0);
            endcase
         end
      end

      // Closing stretch at full rate on both sides.
      queue_csr(REG_MIN_WEIGHT, MIN_WEIGHT_RESET);
      queue_csr(REG_STABLE_THRESHOLD, 200);
      phase_goal = samples_planned + 100;
      while (samples_planned < phase_goal) queue_weighing(1, 200, 1'b1, 1'b0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_jobs.size() != 0 || req_if.valid || issued_count != retired_count)
         @(negedge clock);
      repeat (20) @(negedge clock);

      $display("Run covered %0d samples, %0d register writes and %0d stable events.",
               issued_count, csr_writes, events_seen);
      $display("Status seen: waiting %0d, rising %0d, stabilizing %0d, stable %0d.",
               status_seen[ST_WAITING], status_seen[ST_RISING],
               status_seen[ST_STABILIZING], status_seen[ST_STABLE]);
      if (mismatch_count == 0 && unexpected_count == 0 && expected_words.size() == 0) begin
         $display("PASS weight_stability_detector");
      end else begin
         $display("Mismatches %0d, unexpected words %0d, missing words %0d.",
                  mismatch_count, unexpected_count, expected_words.size());
         $display("FAIL weight_stability_detector");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #5000000;
      $display("Timed out with %0d words outstanding.", expected_words.size());
      $display("FAIL weight_stability_detector");
      $finish;
   end

endmodule

`default_nettype wire
